// ===== rtl/sgmpca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGM path cost aggregation package
// Shared widths, limits, register indexes and reset values for the path cost
// aggregation core.
// ----------------------------------------------------------------------------
package sgmpca_pkg;

    // Highest disparity index of one pixel (disparities 0..MAX_DISP).
    localparam int MAX_DISP_DEFAULT = 63;

    localparam int MATCH_W = 8;
    localparam int COST_W  = 16;
    localparam int AGG_W   = 20;
    localparam int DISP_OUT_W = 6;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [AGG_W-1:0]  AGG_MAX  = {AGG_W{1'b1}};

    localparam logic [CFG_W-1:0] PENALTY_SMALL_RESET = 16'd10;
    localparam logic [CFG_W-1:0] PENALTY_LARGE_RESET = 16'd120;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SMALL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_LARGE = 1'b1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

endpackage

// ===== rtl/sgm_path_cost_aggregation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGM path cost aggregation core
// Computes the semi-global matching path cost along one scan path, one
// disparity per transaction, and adds it to an incoming aggregate cost.
// ----------------------------------------------------------------------------
// Structure: an input transaction lands in the input register, and its
//   computed result moves into the result register once that is free or drained.
// Throughput: one transaction per cycle while the output does not stall; the
//   shift line of the previous pixel's costs advances one entry per transaction.
// Reset: rst_n clears all control state and restores the penalties to their
//   defaults at once; there is no clearing pass. The first pixel after reset
//   is always treated as the start of a new path.
module sgm_path_cost_aggregation_core
    import sgmpca_pkg::*;
#(
    parameter int MAX_DISP = MAX_DISP_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: [7:0] match_cost, [27:8] agg_in, [31:28] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: [0] path_start
    input  logic [0:0]           s_axis_tuser,

    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: [15:0] path_cost, [35:16] agg_out, [41:36] disparity, [47:42] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // tlast: pixel_done, high on the last disparity of the pixel
    output logic                 m_axis_tlast
);

    localparam int DISP_W = (MAX_DISP < 2) ? 1 : $clog2(MAX_DISP + 1);
    localparam logic [DISP_W-1:0] DISP_LAST = DISP_W'(MAX_DISP);

    // ------------------------------------------------------------------------
    // Configuration registers. Write them only while the core is idle; the core does not enforce this.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] penalty_small_reg;
    logic [CFG_W-1:0] penalty_large_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_small_reg <= PENALTY_SMALL_RESET;
            penalty_large_reg <= PENALTY_LARGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PENALTY_SMALL: penalty_small_reg <= cfg_wdata;
                REG_PENALTY_LARGE: penalty_large_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. The input register takes a new transaction whenever it is
    // empty or is handing its item to the compute stage in the same cycle.
    // The compute stage advances when the result register is empty or its
    // content is being taken downstream.
    // ------------------------------------------------------------------------
    logic               in_valid_reg;
    logic [MATCH_W-1:0] in_cost_reg;
    logic               in_start_reg;
    logic [AGG_W-1:0]   in_agg_reg;

    logic               out_valid_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic [AGG_W-1:0]   out_agg_reg;
    logic [DISP_OUT_W-1:0] out_disp_reg;
    logic               out_last_reg;

    logic in_take;
    logic advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cost_reg  <= s_axis_tdata[MATCH_W-1:0];
            in_agg_reg   <= s_axis_tdata[MATCH_W +: AGG_W];
            in_start_reg <= s_axis_tuser[0];
        end
    end

    // ------------------------------------------------------------------------
    // Path state. The previous pixel's cost vector lives in a shift line:
    // entry 0 always holds the previous cost at the current disparity and
    // entry 1 the one just above it. Each transaction shifts the line down by
    // one and appends the new cost at the top, so after a whole pixel the line
    // holds that pixel's vector in disparity order.
    // ------------------------------------------------------------------------
    logic [COST_W-1:0] prev_line [0:MAX_DISP];
    logic [COST_W-1:0] prev_min_reg;
    logic [COST_W-1:0] running_min_reg;
    logic [COST_W-1:0] saved_lower_reg;
    logic [DISP_W-1:0] disp_reg;
    logic              first_pixel_reg;

    logic              last;
    logic              first_eff;
    logic [COST_W:0]   cand_lower;
    logic [COST_W:0]   cand_upper;
    logic [COST_W:0]   cand_jump;
    logic [COST_W:0]   best;
    logic [COST_W+1:0] cost_sum;
    logic [COST_W-1:0] cost;
    logic [AGG_W:0]    agg_sum;
    logic [AGG_W-1:0]  agg;
    logic [COST_W-1:0] running_min_next;

    always_comb
    begin
        last      = (disp_reg == DISP_LAST);
        // The path-start flag counts only on disparity 0 and holds for the
        // whole pixel through first_pixel_reg.
        first_eff = first_pixel_reg || ((disp_reg == '0) && in_start_reg);

        cand_lower = {1'b0, saved_lower_reg} + {1'b0, penalty_small_reg};
        cand_upper = {1'b0, prev_line[1]}    + {1'b0, penalty_small_reg};
        cand_jump  = {1'b0, prev_min_reg}    + {1'b0, penalty_large_reg};

        best = {1'b0, prev_line[0]};
        // Disparity 0 has no lower neighbor, the last disparity no upper one.
        if ((disp_reg != '0) && (cand_lower < best))
        begin
            best = cand_lower;
        end
        if (!last && (cand_upper < best))
        begin
            best = cand_upper;
        end
        if (cand_jump < best)
        begin
            best = cand_jump;
        end

        cost_sum = (COST_W+2)'(in_cost_reg) + {1'b0, best};
        if (first_eff)
        begin
            cost = COST_W'(in_cost_reg);
        end
        else if (cost_sum > (COST_W+2)'(COST_MAX))
        begin
            cost = COST_MAX;
        end
        else
        begin
            cost = cost_sum[COST_W-1:0];
        end

        agg_sum = {1'b0, in_agg_reg} + (AGG_W+1)'(cost);
        agg     = agg_sum[AGG_W] ? AGG_MAX : agg_sum[AGG_W-1:0];

        running_min_next = (cost < running_min_reg) ? cost : running_min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_min_reg    <= '0;
            running_min_reg <= COST_MAX;
            saved_lower_reg <= '0;
            disp_reg        <= '0;
            first_pixel_reg <= 1'b1;
        end
        else if (advance)
        begin
            saved_lower_reg <= prev_line[0];
            if (last)
            begin
                prev_min_reg    <= running_min_next;
                running_min_reg <= COST_MAX;
                disp_reg        <= '0;
                first_pixel_reg <= 1'b0;
            end
            else
            begin
                running_min_reg <= running_min_next;
                disp_reg        <= disp_reg + 1'b1;
                first_pixel_reg <= first_eff;
            end
        end
    end

    // The shift line holds data only; its content is never read on the first
    // pixel after reset, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_DISP; i++)
            begin
                prev_line[i] <= prev_line[i+1];
            end
            prev_line[MAX_DISP] <= cost;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_cost_reg <= cost;
            out_agg_reg  <= agg;
            out_disp_reg <= DISP_OUT_W'(disp_reg);
            out_last_reg <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(M_TDATA_W - COST_W - AGG_W - DISP_OUT_W)'(0),
                            out_disp_reg, out_agg_reg, out_cost_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_disp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        disp_reg <= DISP_LAST)
        else $error("disparity counter beyond the last disparity");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last) |=> (disp_reg == '0) && (running_min_reg == COST_MAX)
                              && !first_pixel_reg)
        else $error("pixel end did not restart the disparity sequence");

    a_agg_covers_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_agg_reg >= AGG_W'(out_cost_reg)))
        else $error("aggregate smaller than the path cost it includes");

    a_min_tracks_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last) |=> (running_min_reg <= $past(cost)))
        else $error("running minimum above a cost of the current pixel");

endmodule
